>>> rtl/dnp3_frame_recognizer_defines.svh
// Assertion macros shared by the frame recognizer RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef DNP3_FRAME_RECOGNIZER_DEFINES_SVH
`define DNP3_FRAME_RECOGNIZER_DEFINES_SVH

// Check that a condition holds at every edge out of reset.
`define DFR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a trigger in one cycle implies a condition in the next.
`define DFR_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/dnp3fr_pkg.sv
// Shared types and constants for the DNP3 link frame recognizer.
// No dependencies.
`timescale 1ns / 1ps

package dnp3fr_pkg;

    localparam int BYTE_W          = 8;
    localparam int COUNT_W         = 8;
    localparam int POS_W           = 9;
    localparam int OFF_W           = 5;

    localparam int CRC_BLOCK_BYTES = 16;
    localparam int CRC_BLOCK_SHIFT = 4;
    localparam int CRC_BYTES       = 2;
    localparam int HDR_BYTES       = 10;

    localparam logic [BYTE_W-1:0]  SYNC_HI   = 8'h05;
    localparam logic [BYTE_W-1:0]  SYNC_LO   = 8'h64;
    localparam logic [BYTE_W-1:0]  MIN_LEN   = 8'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic               recognized;
        logic [COUNT_W-1:0] frame_count;
    } t_scan_res;

endpackage

>>> rtl/dnp3fr_scan.sv
// Frame walker: per-beat header, control and function checks plus frame count.
// Depends on dnp3fr_pkg.
`timescale 1ns / 1ps

module dnp3fr_scan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [dnp3fr_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                             i_last_byte,
    input  logic                             i_first_only,
    output dnp3fr_pkg::t_scan_res            o_res
);

    localparam logic [3:0] FC_PRI_MAX     = 4'd4;
    localparam logic [3:0] FC_PRI_TEST    = 4'd9;
    localparam logic [3:0] FC_SEC_MAX     = 4'd1;
    localparam logic [3:0] FC_SEC_STATUS  = 4'd11;
    localparam logic [3:0] FC_SEC_NSUP    = 4'd14;
    localparam logic [3:0] FC_SEC_NUSED   = 4'd15;
    localparam logic [7:0] AFC_LOW_MAX    = 8'd6;
    localparam logic [7:0] AFC_GAP_END    = 8'd13;
    localparam logic [7:0] AFC_HIGH_MAX   = 8'd23;
    localparam logic [7:0] AFC_RESPONSE   = 8'd129;
    localparam logic [7:0] AFC_UNSOL      = 8'd130;
    localparam logic [7:0] AFC_DATA_IDX   = 8'd2;
    localparam logic [dnp3fr_pkg::POS_W-1:0] POS_HDR_LAST =
        dnp3fr_pkg::POS_W'(dnp3fr_pkg::HDR_BYTES - 1);
    localparam logic [dnp3fr_pkg::OFF_W-1:0] OFF_DATA_END =
        dnp3fr_pkg::OFF_W'(dnp3fr_pkg::CRC_BLOCK_BYTES);
    localparam logic [dnp3fr_pkg::OFF_W-1:0] OFF_LAST =
        dnp3fr_pkg::OFF_W'(dnp3fr_pkg::CRC_BLOCK_BYTES + dnp3fr_pkg::CRC_BYTES - 1);

    function automatic logic control_ok(input logic [3:0] fc, input logic prm);
        if (prm) begin
            return (fc <= FC_PRI_MAX) || (fc == FC_PRI_TEST);
        end
        return (fc <= FC_SEC_MAX) || (fc == FC_SEC_STATUS) ||
               (fc == FC_SEC_NSUP) || (fc == FC_SEC_NUSED);
    endfunction

    function automatic logic function_ok(input logic [7:0] f);
        if (f > AFC_HIGH_MAX) begin
            return (f == AFC_RESPONSE) || (f == AFC_UNSOL);
        end
        return !((f > AFC_LOW_MAX) && (f < AFC_GAP_END));
    endfunction

    logic [dnp3fr_pkg::POS_W-1:0]   r_pos,     n_pos;
    logic [dnp3fr_pkg::BYTE_W-1:0]  r_users,   n_users;
    logic [dnp3fr_pkg::POS_W-1:0]   r_total,   n_total;
    logic [dnp3fr_pkg::OFF_W-1:0]   r_off,     n_off;
    logic [dnp3fr_pkg::BYTE_W-1:0]  r_didx,    n_didx;
    logic [dnp3fr_pkg::COUNT_W-1:0] r_count,   n_count;
    logic                           r_stopped, n_stopped;
    logic                           r_seen,    n_seen;

    logic [dnp3fr_pkg::BYTE_W-1:0]  len_users;
    logic [dnp3fr_pkg::OFF_W-1:0]   len_blocks;
    logic [dnp3fr_pkg::POS_W-1:0]   pos_inc;
    logic                           body_ok;
    logic                           count_hit;

    assign len_users  = i_data_byte - dnp3fr_pkg::MIN_LEN;
    assign len_blocks = dnp3fr_pkg::OFF_W'(
        ({1'b0, len_users} + 9'(dnp3fr_pkg::CRC_BLOCK_BYTES - 1))
        >> dnp3fr_pkg::CRC_BLOCK_SHIFT);
    assign pos_inc    = r_pos + 1'b1;

    always_comb begin
        n_pos     = r_pos;
        n_users   = r_users;
        n_total   = r_total;
        n_off     = r_off;
        n_didx    = r_didx;
        n_count   = r_count;
        n_stopped = r_stopped;
        n_seen    = r_seen;
        body_ok   = 1'b1;
        count_hit = 1'b0;

        if (i_step && !r_stopped) begin
            if (r_pos == '0) begin
                if (i_data_byte != dnp3fr_pkg::SYNC_HI) begin
                    n_stopped = 1'b1;
                end else begin
                    n_seen = 1'b1;
                    n_pos  = pos_inc;
                end
            end else if (r_pos == 9'd1) begin
                if (!r_seen || i_data_byte != dnp3fr_pkg::SYNC_LO) begin
                    n_stopped = 1'b1;
                end else begin
                    n_pos = pos_inc;
                end
            end else if (r_pos == 9'd2) begin
                if (i_data_byte < dnp3fr_pkg::MIN_LEN) begin
                    n_stopped = 1'b1;
                end else begin
                    n_users = len_users;
                    n_total = 9'(dnp3fr_pkg::HDR_BYTES) + {1'b0, len_users}
                              + {3'b0, len_blocks, 1'b0};
                    n_pos   = pos_inc;
                end
            end else begin
                if (r_pos == 9'd3 && !control_ok(i_data_byte[3:0], i_data_byte[6])) begin
                    body_ok = 1'b0;
                end
                if (body_ok) begin
                    if (r_pos <= POS_HDR_LAST) begin
                        count_hit = (r_pos == POS_HDR_LAST) && (r_users == '0);
                    end else begin
                        if (r_off < OFF_DATA_END && r_didx < r_users) begin
                            if (r_didx == AFC_DATA_IDX && !function_ok(i_data_byte)) begin
                                body_ok = 1'b0;
                            end else begin
                                count_hit = (r_didx == r_users - 1'b1);
                            end
                        end
                        n_off = (r_off == OFF_LAST) ? '0 : r_off + 1'b1;
                        if (r_off < OFF_DATA_END) begin
                            n_didx = r_didx + 1'b1;
                        end
                    end
                end
                if (!body_ok) begin
                    n_stopped = 1'b1;
                end else begin
                    if (count_hit) begin
                        if (r_count != dnp3fr_pkg::COUNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                        if (i_first_only) begin
                            n_stopped = 1'b1;
                        end
                    end
                    if (pos_inc >= r_total) begin
                        n_pos   = '0;
                        n_seen  = 1'b0;
                        n_users = '0;
                        n_off   = '0;
                        n_didx  = '0;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
            end
        end

        o_res.recognized  = (n_count != '0);
        o_res.frame_count = n_count;

        if (i_step && i_last_byte) begin
            n_pos     = '0;
            n_users   = '0;
            n_total   = '0;
            n_off     = '0;
            n_didx    = '0;
            n_count   = '0;
            n_stopped = 1'b0;
            n_seen    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_users   <= '0;
            r_total   <= '0;
            r_off     <= '0;
            r_didx    <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
            r_seen    <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_users   <= n_users;
            r_total   <= n_total;
            r_off     <= n_off;
            r_didx    <= n_didx;
            r_count   <= n_count;
            r_stopped <= n_stopped;
            r_seen    <= n_seen;
        end
    end

endmodule

>>> rtl/dnp3_frame_recognizer.sv
// DNP3 link frame recognizer top level: input register, frame walker, result register.
// Depends on dnp3fr_pkg, dnp3fr_scan and dnp3_frame_recognizer_defines.svh.
//
// Usage:
//   Payload bytes enter one beat at a time on i_valid/o_ready with i_data_byte and
//   i_last_byte; i_last_byte marks the final byte of a payload.
//   Each beat with i_last_byte set yields one result beat on o_valid/i_ready:
//   o_recognized and o_frame_count (valid frames, saturating at 255).
//   Other beats yield no result.
//   A final byte's result is registered in the result register after the input register.
//   Throughput: one byte per cycle unless a final byte is held; one walker pass per beat.
//   While a result waits, non-final bytes still flow; a final byte holds in the
//   input register until the result register frees, so o_ready drops then.
//   i_cfg_we/i_cfg_data write first_frame_only; write only while the block is idle.
//   Reset (synchronous, active low) clears the scan state, the configuration
//   bit and both registers' valid flags. The scan state also clears after each
//   payload's final byte.
`timescale 1ns / 1ps
`include "dnp3_frame_recognizer_defines.svh"

module dnp3_frame_recognizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [dnp3fr_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                             i_last_byte,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_recognized,
    output logic [dnp3fr_pkg::COUNT_W-1:0]   o_frame_count,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_data
);

    logic                            r_first_only;
    logic                            r_in_valid;
    logic [dnp3fr_pkg::BYTE_W-1:0]   r_in_byte;
    logic                            r_in_last;
    logic                            r_out_valid;
    dnp3fr_pkg::t_scan_res           r_out;
    dnp3fr_pkg::t_scan_res           scan_res;
    logic                            step;
    logic                            out_free;

    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign o_ready  = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_only <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_first_only <= i_cfg_data;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (step && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (step && r_in_last) begin
            r_out <= scan_res;
        end
    end

    dnp3fr_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .i_first_only (r_first_only),
        .o_res        (scan_res)
    );

    assign o_valid       = r_out_valid;
    assign o_recognized  = r_out.recognized;
    assign o_frame_count = r_out.frame_count;

    `DFR_ASSERT_ALWAYS(a_rec_matches_count, !o_valid || (o_recognized == (o_frame_count != '0)), "recognized flag disagrees with frame count")
    `DFR_ASSERT_NEXT(a_last_gives_result, step && r_in_last, r_out_valid, "final beat produced no result")
    `DFR_ASSERT_ALWAYS(a_stall_only_when_full, o_ready || (r_in_valid && r_in_last && r_out_valid), "input stalled without a pending result")

endmodule

>>> dv/dnp3_frame_recognizer_tb.sv
// Self-checking testbench for dnp3_frame_recognizer: directed and random DNP3 link payloads.
// A frame walker in the bench predicts each end-of-payload report; reports are checked in order.
// Depends on dnp3fr_pkg and the dnp3_frame_recognizer RTL.
`timescale 1ns / 1ps

module dnp3_frame_recognizer_tb;

    localparam int CYCLE_LIMIT = 100000;

    localparam logic [3:0] FC_RESET_LINK      = 4'd0;
    localparam logic [3:0] FC_UNCONFIRMED     = 4'd4;
    localparam logic [3:0] FC_REQ_LINK_STATUS = 4'd9;
    localparam logic [3:0] FC_NACK            = 4'd1;
    localparam logic [3:0] FC_LINK_STATUS     = 4'd11;
    localparam logic [3:0] FC_NOT_FUNCTIONING = 4'd14;
    localparam logic [3:0] FC_NOT_SUPPORTED   = 4'd15;

    localparam logic [7:0] APP_FN_LOW_MAX     = 8'd6;
    localparam logic [7:0] APP_FN_MID_MIN     = 8'd13;
    localparam logic [7:0] APP_FN_MID_MAX     = 8'd23;
    localparam logic [7:0] APP_FN_RESPONSE    = 8'd129;
    localparam logic [7:0] APP_FN_UNSOLICITED = 8'd130;

    typedef enum int {
        BREAK_SYNC_HI,
        BREAK_SYNC_LO,
        BREAK_LENGTH,
        BREAK_CONTROL,
        BREAK_APP_FN
    } t_break;

    logic                               i_clk;
    logic                               i_rst_n       = 1'b0;
    logic                               i_valid       = 1'b0;
    logic                               o_ready;
    logic [dnp3fr_pkg::BYTE_W-1:0]      i_data_byte   = '0;
    logic                               i_last_byte   = 1'b0;
    logic                               o_valid;
    logic                               i_ready       = 1'b0;
    logic                               o_recognized;
    logic [dnp3fr_pkg::COUNT_W-1:0]     o_frame_count;
    logic                               i_cfg_we      = 1'b0;
    logic                               i_cfg_data    = 1'b0;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    dnp3fr_pkg::t_scan_res expected_reports[$];

    logic                               cfg_first_only;
    logic [dnp3fr_pkg::POS_W-1:0]       walk_pos;
    logic [7:0]                         walk_len;
    logic                               walk_prm;
    logic [dnp3fr_pkg::COUNT_W-1:0]     walk_frames;
    logic                               walk_stopped;
    logic                               walk_synced;

    dnp3_frame_recognizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_recognized  (o_recognized),
        .o_frame_count (o_frame_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        dnp3fr_pkg::t_scan_res exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected report: recognized %0d frame_count %0d",
                       o_recognized, o_frame_count);
                mismatches++;
            end else begin
                exp_res = expected_reports.pop_front();
                if (o_recognized !== exp_res.recognized) begin
                    $error("recognized mismatch: expected %0d, actual %0d",
                           exp_res.recognized, o_recognized);
                    mismatches++;
                end
                if (o_frame_count !== exp_res.frame_count) begin
                    $error("frame_count mismatch: expected %0d, actual %0d",
                           exp_res.frame_count, o_frame_count);
                    mismatches++;
                end
            end
        end
    end

    function automatic bit control_ok(logic [3:0] fc, logic prm);
        if (prm)
            return fc <= FC_UNCONFIRMED || fc == FC_REQ_LINK_STATUS;
        return fc <= FC_NACK || fc == FC_LINK_STATUS || fc == FC_NOT_FUNCTIONING ||
               fc == FC_NOT_SUPPORTED;
    endfunction

    function automatic bit app_fn_ok(logic [7:0] f);
        if (f > APP_FN_MID_MAX)
            return f == APP_FN_RESPONSE || f == APP_FN_UNSOLICITED;
        return !(f > APP_FN_LOW_MAX && f < APP_FN_MID_MIN);
    endfunction

    function automatic void clear_walk();
        walk_pos     = '0;
        walk_len     = '0;
        walk_prm     = 1'b0;
        walk_frames  = '0;
        walk_stopped = 1'b0;
        walk_synced  = 1'b0;
    endfunction

    function automatic void count_frame();
        if (walk_frames != dnp3fr_pkg::COUNT_MAX)
            walk_frames++;
        if (cfg_first_only)
            walk_stopped = 1'b1;
    endfunction

    function automatic void walk_byte(logic [7:0] b);
        int p, users, total, q, off, d;
        p = int'(walk_pos);
        if (p == 0) begin
            if (b != dnp3fr_pkg::SYNC_HI) begin
                walk_stopped = 1'b1;
                return;
            end
            walk_synced = 1'b1;
            walk_pos = dnp3fr_pkg::POS_W'(1);
            return;
        end
        if (p == 1) begin
            if (!walk_synced || b != dnp3fr_pkg::SYNC_LO) begin
                walk_stopped = 1'b1;
                return;
            end
            walk_pos = dnp3fr_pkg::POS_W'(2);
            return;
        end
        if (p == 2) begin
            if (b < dnp3fr_pkg::MIN_LEN) begin
                walk_stopped = 1'b1;
                return;
            end
            walk_len = b;
            walk_pos = dnp3fr_pkg::POS_W'(3);
            return;
        end
        if (p == 3) begin
            walk_prm = b[6];
            if (!control_ok(b[3:0], walk_prm)) begin
                walk_stopped = 1'b1;
                return;
            end
        end
        users = (walk_len >= dnp3fr_pkg::MIN_LEN) ?
                int'(walk_len) - int'(dnp3fr_pkg::MIN_LEN) : 0;
        total = dnp3fr_pkg::HDR_BYTES + users + dnp3fr_pkg::CRC_BYTES *
                ((users + dnp3fr_pkg::CRC_BLOCK_BYTES - 1) / dnp3fr_pkg::CRC_BLOCK_BYTES);
        if (p < dnp3fr_pkg::HDR_BYTES) begin
            if (p == dnp3fr_pkg::HDR_BYTES - 1 && users == 0)
                count_frame();
        end else begin
            q   = p - dnp3fr_pkg::HDR_BYTES;
            off = q % (dnp3fr_pkg::CRC_BLOCK_BYTES + dnp3fr_pkg::CRC_BYTES);
            d   = (q / (dnp3fr_pkg::CRC_BLOCK_BYTES + dnp3fr_pkg::CRC_BYTES)) *
                  dnp3fr_pkg::CRC_BLOCK_BYTES + off;
            if (off < dnp3fr_pkg::CRC_BLOCK_BYTES && d < users) begin
                if (d == 2 && !app_fn_ok(b)) begin
                    walk_stopped = 1'b1;
                    return;
                end
                if (d == users - 1)
                    count_frame();
            end
        end
        if (p + 1 >= total) begin
            walk_pos    = '0;
            walk_synced = 1'b0;
            walk_len    = '0;
            walk_prm    = 1'b0;
        end else begin
            walk_pos = dnp3fr_pkg::POS_W'(p + 1);
        end
    endfunction

    function automatic void predict_beat(logic [7:0] b, logic last);
        dnp3fr_pkg::t_scan_res r;
        if (!walk_stopped)
            walk_byte(b);
        if (last) begin
            r.recognized  = (walk_frames != '0);
            r.frame_count = walk_frames;
            expected_reports.push_back(r);
            clear_walk();
        end
    endfunction

    function automatic logic [7:0] pick_control(bit good);
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (control_ok(c[3:0], c[6]) != good);
        return c;
    endfunction

    function automatic logic [7:0] pick_app_fn(bit good);
        logic [7:0] f;
        do f = 8'($urandom_range(255)); while (app_fn_ok(f) != good);
        return f;
    endfunction

    function automatic logic [7:0] pick_other(logic [7:0] v);
        logic [7:0] x;
        do x = 8'($urandom_range(255)); while (x == v);
        return x;
    endfunction

    function automatic int rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return $urandom_range(10, 5);
        if (r < 90)
            return $urandom_range(40, 11);
        if (r < 97)
            return $urandom_range(120, 41);
        return $urandom_range(255, 121);
    endfunction

    function automatic void add_frame(ref logic [7:0] stream[$], input int len,
                                      input logic [7:0] ctrl, input logic [7:0] app_fn);
        int users;
        users = (len >= int'(dnp3fr_pkg::MIN_LEN)) ? len - int'(dnp3fr_pkg::MIN_LEN) : 0;
        stream.push_back(dnp3fr_pkg::SYNC_HI);
        stream.push_back(dnp3fr_pkg::SYNC_LO);
        stream.push_back(8'(len));
        stream.push_back(ctrl);
        repeat (6) stream.push_back(8'($urandom_range(255)));
        for (int i = 0; i < users; i++) begin
            stream.push_back((i == 2) ? app_fn : 8'($urandom_range(255)));
            if (i % dnp3fr_pkg::CRC_BLOCK_BYTES == dnp3fr_pkg::CRC_BLOCK_BYTES - 1 ||
                i == users - 1)
                repeat (dnp3fr_pkg::CRC_BYTES) stream.push_back(8'($urandom_range(255)));
        end
    endfunction

    function automatic void add_good_frame(ref logic [7:0] stream[$], input int len);
        add_frame(stream, len, pick_control(1'b1), pick_app_fn(1'b1));
    endfunction

    function automatic void add_broken_frame(ref logic [7:0] stream[$]);
        int     start, len;
        t_break kind;
        start = stream.size();
        kind  = t_break'($urandom_range(BREAK_APP_FN));
        len   = (kind == BREAK_APP_FN) ? $urandom_range(40, 8) : rand_len();
        add_good_frame(stream, len);
        case (kind)
            BREAK_SYNC_HI: stream[start]     = pick_other(dnp3fr_pkg::SYNC_HI);
            BREAK_SYNC_LO: stream[start + 1] = pick_other(dnp3fr_pkg::SYNC_LO);
            BREAK_LENGTH:  stream[start + 2] = 8'($urandom_range(dnp3fr_pkg::MIN_LEN - 1));
            BREAK_CONTROL: stream[start + 3] = pick_control(1'b0);
            default:       stream[start + dnp3fr_pkg::HDR_BYTES + 2] = pick_app_fn(1'b0);
        endcase
    endfunction

    function automatic void add_noise(ref logic [7:0] stream[$], input int n);
        repeat (n) stream.push_back(8'($urandom_range(255)));
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(logic [7:0] data, logic last);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_beat(data, last);
        @(negedge i_clk);
    endtask

    task automatic send_payload(ref logic [7:0] stream[$]);
        for (int i = 0; i < stream.size(); i++)
            send_byte(stream[i], i == stream.size() - 1);
    endtask

    task automatic drain_block();
        i_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_first_only = value;
    endtask

    task automatic test_single_byte_payloads();
        logic [7:0] stream[$];
        stream = '{8'h00};
        send_payload(stream);
        stream = '{8'hFF};
        send_payload(stream);
        stream = '{dnp3fr_pkg::SYNC_HI};
        send_payload(stream);
        stream = '{dnp3fr_pkg::SYNC_HI, dnp3fr_pkg::SYNC_LO};
        send_payload(stream);
        drain_block();
    endtask

    task automatic test_control_functions();
        logic [7:0] stream[$];
        for (int c = 0; c < 8; c++) begin
            stream.delete();
            add_frame(stream, 5, pick_control(c[0] == 1'b0), 8'h00);
            send_payload(stream);
        end
        drain_block();
    endtask

    task automatic test_app_functions();
        logic [7:0] stream[$];
        logic [7:0] codes[$];
        codes = '{8'd6, 8'd7, 8'd13, 8'd24, 8'd130, 8'd131};
        foreach (codes[i]) begin
            stream.delete();
            add_frame(stream, 8, pick_control(1'b1), codes[i]);
            send_payload(stream);
        end
        drain_block();
    endtask

    task automatic test_frame_lengths();
        logic [7:0] stream[$];
        int lens[$];
        lens = '{5, 6, 21, 22};
        foreach (lens[i])
            add_good_frame(stream, lens[i]);
        send_payload(stream);
        stream.delete();
        add_frame(stream, 4, pick_control(1'b1), 8'h00);
        send_payload(stream);
        stream.delete();
        add_frame(stream, 0, pick_control(1'b1), 8'h00);
        send_payload(stream);
        drain_block();
    endtask

    task automatic test_truncation_and_stop();
        logic [7:0] stream[$];
        add_good_frame(stream, 12);
        add_good_frame(stream, 20);
        repeat (7) void'(stream.pop_back());
        send_payload(stream);
        stream.delete();
        add_good_frame(stream, 5);
        add_broken_frame(stream);
        add_good_frame(stream, 5);
        add_noise(stream, 5);
        send_payload(stream);
        stream.delete();
        add_noise(stream, 3);
        add_good_frame(stream, 9);
        send_payload(stream);
        drain_block();
    endtask

    task automatic test_first_frame_only();
        logic [7:0] stream[$];
        write_cfg(1'b1);
        add_good_frame(stream, 5);
        add_good_frame(stream, 18);
        add_good_frame(stream, 7);
        send_payload(stream);
        stream.delete();
        add_good_frame(stream, 9);
        send_payload(stream);
        drain_block();
        write_cfg(1'b0);
    endtask

    task automatic build_random_payload(ref logic [7:0] stream[$]);
        int r, k;
        r = $urandom_range(99);
        if (r < 70) begin
            repeat ($urandom_range(3, 1)) add_good_frame(stream, rand_len());
            if ($urandom_range(99) < 15) begin
                k = $urandom_range((stream.size() > 12) ? 12 : stream.size() - 1, 1);
                repeat (k) void'(stream.pop_back());
            end else if ($urandom_range(99) < 10) begin
                add_noise(stream, $urandom_range(6, 1));
            end
        end else if (r < 88) begin
            repeat ($urandom_range(2)) add_good_frame(stream, rand_len());
            add_broken_frame(stream);
            add_noise(stream, $urandom_range(8));
        end else begin
            add_noise(stream, $urandom_range(8, 1));
        end
    endtask

    task automatic test_random_traffic(int target_bytes, int min_payloads);
        logic [7:0] stream[$];
        int sent, payloads;
        sent     = 0;
        payloads = 0;
        while (sent < target_bytes || payloads < min_payloads) begin
            stream.delete();
            build_random_payload(stream);
            send_payload(stream);
            sent += stream.size();
            payloads++;
            if ($urandom_range(7) == 0) begin
                drain_block();
                write_cfg(1'($urandom_range(1)));
            end
        end
        drain_block();
    endtask

    initial begin
        cfg_first_only = 1'b0;
        clear_walk();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        snd_idle_pct  = 32;
        rcv_stall_pct = 87;
        write_cfg(1'b0);
        test_single_byte_payloads();
        test_control_functions();
        test_app_functions();
        test_frame_lengths();
        test_truncation_and_stop();
        test_first_frame_only();
        test_random_traffic(30, 2);

        snd_idle_pct  = 87;
        rcv_stall_pct = 32;
        write_cfg(1'b1);
        test_random_traffic(30, 2);

        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        write_cfg(1'b0);
        test_random_traffic(30, 2);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
